@@ src/smpf_pkg.sv @@
// Shared types and constants for the serial mouse packet filter.
package smpf_pkg;

    // Item kinds on the input channel
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOLD_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_SPEED_LAW_EN = 2'd1;
    localparam logic [1:0] CFG_MOTION_CAP   = 2'd2;
    localparam logic [1:0] CFG_JITTER_TICKS = 2'd3;

    // Configuration reset values
    localparam logic [6:0] HOLD_RADIUS_RST  = 7'd1;
    localparam logic       SPEED_LAW_EN_RST = 1'b0;
    localparam logic [6:0] MOTION_CAP_RST   = 7'd48;
    localparam logic [7:0] JITTER_TICKS_RST = 8'd8;

    // Sync byte: upper nibble 1000b
    localparam logic [3:0] SYNC_NIBBLE = 4'h8;
    localparam logic [2:0] LAST_BUTTONS_RST = 3'b111;

    typedef struct packed {
        logic [6:0] hold_radius;
        logic       speed_law_enable;
        logic [6:0] motion_cap;
        logic [7:0] jitter_ticks;
    } smpf_cfg_t;

    typedef struct packed {
        logic [2:0] buttons;
        logic [7:0] delta_x;
        logic [7:0] delta_y;
        logic       speed_exceeded;
        logic       three_byte_mode;
    } smpf_result_t;

endpackage

@@ src/smpf_in_reg.sv @@
// Input register stage: holds one accepted item until the core consumes it.
module smpf_in_reg
    import smpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic       item_action,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic       action_reg;
    logic [7:0] byte_reg;
    logic       load;

    // Stall only while a held item cannot move on
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action;
            byte_reg   <= rx_byte;
        end
    end

    assign item_valid  = valid_reg;
    assign item_action = action_reg;
    assign item_byte   = byte_reg;

endmodule

@@ src/smpf_core.sv @@
// Packet parser, motion sums, jitter hold and sample shaping.
module smpf_core
    import smpf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  smpf_cfg_t    cfg,
    input  logic         fire,
    input  logic         item_action,
    input  logic [7:0]   item_byte,
    output logic         res_valid,
    output smpf_result_t res
);

    typedef enum logic [4:0] {
        PH_SYNC = 5'b00001,
        PH_X1   = 5'b00010,
        PH_Y1   = 5'b00100,
        PH_X2   = 5'b01000,
        PH_Y2   = 5'b10000
    } phase_t;

    // Saturating signed add
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {a[7], a} + {b[7], b};
        if (s[8] != s[7])
        begin
            sat_add = s[8] ? 8'h80 : 8'h7f;
        end
        else
        begin
            sat_add = s[7:0];
        end
    endfunction

    // Saturating signed subtract
    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {a[7], a} - {b[7], b};
        if (s[8] != s[7])
        begin
            sat_sub = s[8] ? 8'h80 : 8'h7f;
        end
        else
        begin
            sat_sub = s[7:0];
        end
    endfunction

    // Magnitude as unsigned; -128 gives 128
    function automatic logic [7:0] mag8(input logic [7:0] a);
        mag8 = a[7] ? (~a + 8'd1) : a;
    endfunction

    phase_t     phase_reg, phase_next;
    logic       fmt_reg, fmt_next;
    logic [7:0] sum_x_reg, sum_x_next;
    logic [7:0] sum_y_reg, sum_y_next;
    logic [2:0] cur_btn_reg, cur_btn_next;
    logic [2:0] last_btn_reg, last_btn_next;
    logic       pending_reg, pending_next;
    logic [7:0] count_reg, count_next;

    logic [7:0] sx_w, sy_w;
    logic [2:0] btn_w;
    logic       fmt_w;
    logic       emit_now;
    logic       is_sync;
    logic       pkt_done;
    logic [7:0] radius;
    logic       in_radius;

    logic [7:0] limit;
    logic       over_x, over_y;
    logic [7:0] x_law, y_law;
    logic [7:0] x_out, y_out;
    logic [7:0] carry_x, carry_y;

    assign is_sync   = (item_byte[7:4] == SYNC_NIBBLE);
    assign radius    = fmt_w ? {cfg.hold_radius, 1'b0} : {1'b0, cfg.hold_radius};
    assign in_radius = (mag8(sx_w) <= radius) && (mag8(sy_w) <= radius);

    // Parse one item and decide on a sample
    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        last_btn_next = last_btn_reg;
        sx_w          = sum_x_reg;
        sy_w          = sum_y_reg;
        btn_w         = cur_btn_reg;
        fmt_w         = fmt_reg;
        emit_now      = 1'b0;
        pkt_done      = 1'b0;
        if (fire)
        begin
            if (item_action == ACT_TICK)
            begin
                // Count down a held sample
                if (pending_reg)
                begin
                    if (count_reg <= 8'd1)
                    begin
                        pending_next = 1'b0;
                        count_next   = 8'd0;
                        emit_now     = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 8'd1;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_X1, PH_X2:
                    begin
                        sx_w = sat_add(sum_x_reg, item_byte);
                    end
                    PH_Y1, PH_Y2:
                    begin
                        sy_w = sat_sub(sum_y_reg, item_byte);
                    end
                    default:
                    begin
                        if (is_sync)
                        begin
                            btn_w = item_byte[2:0];
                            fmt_w = item_byte[3];
                        end
                    end
                endcase

                pkt_done = (phase_reg == PH_Y2) || (fmt_w && phase_reg == PH_Y1);

                case (phase_reg)
                    PH_X1:   phase_next = PH_Y1;
                    PH_Y1:   phase_next = fmt_w ? PH_SYNC : PH_X2;
                    PH_X2:   phase_next = PH_Y2;
                    PH_Y2:   phase_next = PH_SYNC;
                    default: phase_next = is_sync ? PH_X1 : PH_SYNC;
                endcase

                // Judge the finished packet
                if (pkt_done)
                begin
                    pending_next = 1'b0;
                    if (btn_w == last_btn_reg && sx_w == 8'd0 && sy_w == 8'd0)
                    begin
                        emit_now = 1'b0;
                    end
                    else if (btn_w == last_btn_reg && in_radius)
                    begin
                        pending_next = 1'b1;
                        count_next   = cfg.jitter_ticks;
                    end
                    else
                    begin
                        last_btn_next = btn_w;
                        emit_now      = 1'b1;
                    end
                end
            end
        end
    end

    // Shape the sample: speed law, then halving for the three-byte format
    assign limit  = fmt_w ? {cfg.motion_cap, 1'b0} : {1'b0, cfg.motion_cap};
    assign over_x = cfg.speed_law_enable && (mag8(sx_w) > limit);
    assign over_y = cfg.speed_law_enable && (mag8(sy_w) > limit);
    assign x_law  = over_x ? 8'd0 : sx_w;
    assign y_law  = over_y ? 8'd0 : sy_w;

    always_comb
    begin
        if (fmt_w)
        begin
            x_out   = {x_law[7], x_law[7:1]};
            y_out   = {y_law[7], y_law[7:1]};
            carry_x = {7'd0, x_law[0]};
            carry_y = {7'd0, y_law[0]};
        end
        else
        begin
            x_out   = x_law;
            y_out   = y_law;
            carry_x = 8'd0;
            carry_y = 8'd0;
        end
    end

    // Sums keep only the carried bits after a sample
    assign sum_x_next   = emit_now ? carry_x : sx_w;
    assign sum_y_next   = emit_now ? carry_y : sy_w;
    assign cur_btn_next = btn_w;
    assign fmt_next     = fmt_w;

    assign res_valid           = emit_now;
    assign res.buttons         = btn_w;
    assign res.delta_x         = x_out;
    assign res.delta_y         = y_out;
    assign res.speed_exceeded  = over_x || over_y;
    assign res.three_byte_mode = fmt_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC;
            fmt_reg      <= 1'b0;
            sum_x_reg    <= 8'd0;
            sum_y_reg    <= 8'd0;
            cur_btn_reg  <= 3'd0;
            last_btn_reg <= LAST_BUTTONS_RST;
            pending_reg  <= 1'b0;
            count_reg    <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fmt_reg      <= fmt_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            cur_btn_reg  <= cur_btn_next;
            last_btn_reg <= last_btn_next;
            pending_reg  <= pending_next;
            count_reg    <= count_next;
        end
    end

endmodule

@@ src/smpf_out_reg.sv @@
// Result register: holds one sample until the receiver takes it.
module smpf_out_reg
    import smpf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic         res_valid,
    input  smpf_result_t res,
    output logic         room,
    output logic         out_valid,
    input  logic         out_stall,
    output smpf_result_t out_res
);

    logic         valid_reg;
    logic         valid_next;
    smpf_result_t data_reg;
    logic         load;

    // Room when empty or when the held item leaves this cycle
    assign room = !valid_reg || !out_stall;
    assign load = fire && res_valid;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

@@ src/serial_mouse_packet_filter_top.sv @@
// Top level of the serial mouse packet filter.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_stall   action, rx_byte
//  out      output     out_valid / out_stall buttons, delta_x, delta_y,
//                                            speed_exceeded, three_byte_mode
//  cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// One item per cycle sustained while the output does not stall; an accepted item
// is loaded into the input register and, once the result register has room,
// moves through the core logic, and any sample it yields is loaded into the
// result register. Reset clears the parser, sums, jitter hold and the
// configuration to its defaults. A stall on the output holds the result
// register, then the input register, then the input channel.
module serial_mouse_packet_filter_top
    import smpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        buttons,
    output logic signed [7:0] delta_x,
    output logic signed [7:0] delta_y,
    output logic              speed_exceeded,
    output logic              three_byte_mode
);

    smpf_cfg_t    cfg_reg;
    smpf_cfg_t    cfg_next;
    logic         item_valid;
    logic         item_action;
    logic [7:0]   item_byte;
    logic         room;
    logic         fire;
    logic         res_valid;
    smpf_result_t res;
    smpf_result_t out_res;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HOLD_RADIUS:  cfg_next.hold_radius      = cfg_data[6:0];
                CFG_SPEED_LAW_EN: cfg_next.speed_law_enable = cfg_data[0];
                CFG_MOTION_CAP:   cfg_next.motion_cap       = cfg_data[6:0];
                CFG_JITTER_TICKS: cfg_next.jitter_ticks     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_radius      <= HOLD_RADIUS_RST;
            cfg_reg.speed_law_enable <= SPEED_LAW_EN_RST;
            cfg_reg.motion_cap       <= MOTION_CAP_RST;
            cfg_reg.jitter_ticks     <= JITTER_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the held item when the result register has room
    assign fire = item_valid && room;

    smpf_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .rx_byte     (rx_byte),
        .advance     (fire),
        .item_valid  (item_valid),
        .item_action (item_action),
        .item_byte   (item_byte)
    );

    smpf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fire        (fire),
        .item_action (item_action),
        .item_byte   (item_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    smpf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign buttons         = out_res.buttons;
    assign delta_x         = out_res.delta_x;
    assign delta_y         = out_res.delta_y;
    assign speed_exceeded  = out_res.speed_exceeded;
    assign three_byte_mode = out_res.three_byte_mode;

endmodule

@@ tb/sv/smpf_sample_audit.sv @@
// Watches the serial mouse filter channels, predicts each emitted sample and checks it.
`timescale 1ns / 1ps

module smpf_sample_audit
    import smpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              action,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        buttons,
    input  logic signed [7:0] delta_x,
    input  logic signed [7:0] delta_y,
    input  logic              speed_exceeded,
    input  logic              three_byte_mode,
    output int                mismatch_count,
    output int                samples_owed
);

    // Packet parser positions
    localparam logic [2:0] AT_SYNC = 3'd0;
    localparam logic [2:0] AT_X1   = 3'd1;
    localparam logic [2:0] AT_Y1   = 3'd2;
    localparam logic [2:0] AT_X2   = 3'd3;
    localparam logic [2:0] AT_Y2   = 3'd4;

    // Register copies
    logic [6:0] radius;
    logic       law_on;
    logic [6:0] law_limit;
    logic [7:0] hold_ticks;

    // Decoder state
    logic [2:0]        phase;
    logic              short_fmt;
    logic signed [7:0] acc_x;
    logic signed [7:0] acc_y;
    logic [2:0]        btn_now;
    logic [2:0]        btn_prev;
    logic              hold_armed;
    logic [7:0]        hold_count;

    smpf_result_t samples_due[$];
    int fault_tally = 0;
    int owed = 0;

    assign mismatch_count = fault_tally;
    assign samples_owed   = owed;

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [7:0] clamp8(input int v);
        if (v > 127)
            return 8'sd127;
        if (v < -128)
            return -8'sd128;
        return v[7:0];
    endfunction

    // Build a sample from the sums; keep only the carried low bits afterwards
    function automatic smpf_result_t take_sample();
        int x;
        int y;
        int lim;
        int carry_x;
        int carry_y;
        logic over;
        smpf_result_t s;
        x = int'(acc_x);
        y = int'(acc_y);
        over = 1'b0;
        carry_x = 0;
        carry_y = 0;
        if (law_on)
        begin
            lim = int'(law_limit) * (short_fmt ? 2 : 1);
            if (mag(x) > lim)
            begin
                x = 0;
                over = 1'b1;
            end
            if (mag(y) > lim)
            begin
                y = 0;
                over = 1'b1;
            end
        end
        if (short_fmt)
        begin
            carry_x = x & 1;
            carry_y = y & 1;
            x = (x - carry_x) / 2;
            y = (y - carry_y) / 2;
        end
        s.buttons         = btn_now;
        s.delta_x         = x[7:0];
        s.delta_y         = y[7:0];
        s.speed_exceeded  = over;
        s.three_byte_mode = short_fmt;
        acc_x = carry_x[7:0];
        acc_y = carry_y[7:0];
        return s;
    endfunction

    // Advance the decoder by one item; return 1 when it emits a sample
    function automatic logic advance_decoder(input logic act, input logic [7:0] c,
                                             output smpf_result_t s);
        logic done;
        int x;
        int y;
        int r;
        s = '0;
        if (act == ACT_TICK)
        begin
            if (!hold_armed)
                return 1'b0;
            if (hold_count <= 8'd1)
            begin
                hold_armed = 1'b0;
                hold_count = 8'd0;
                s = take_sample();
                return 1'b1;
            end
            hold_count = hold_count - 8'd1;
            return 1'b0;
        end

        case (phase)
            AT_X1, AT_X2: acc_x = clamp8(int'(acc_x) + int'($signed(c)));
            AT_Y1, AT_Y2: acc_y = clamp8(int'(acc_y) - int'($signed(c)));
            default:
            begin
                phase = AT_SYNC;
                if (c[7:4] != SYNC_NIBBLE)
                    return 1'b0;
                btn_now   = c[2:0];
                short_fmt = c[3];
            end
        endcase

        done = (phase == AT_Y2) || (short_fmt && phase == AT_Y1);
        if (!done)
        begin
            phase = phase + 3'd1;
            return 1'b0;
        end
        phase = AT_SYNC;

        // A finished packet cancels any held motion before it is judged
        hold_armed = 1'b0;
        if (btn_now == btn_prev)
        begin
            x = int'(acc_x);
            y = int'(acc_y);
            r = int'(radius) * (short_fmt ? 2 : 1);
            if (x == 0 && y == 0)
                return 1'b0;
            if (mag(x) <= r && mag(y) <= r)
            begin
                hold_armed = 1'b1;
                hold_count = hold_ticks;
                return 1'b0;
            end
        end
        btn_prev = btn_now;
        s = take_sample();
        return 1'b1;
    endfunction

    task automatic report_fault(input string why, input smpf_result_t want,
                                input smpf_result_t got);
        fault_tally++;
        if (fault_tally <= 10)
            $display("%t sample %s: expected btn=%0d dx=%0d dy=%0d spd=%0d fmt=%0d,",
                     $time, why, want.buttons, $signed(want.delta_x),
                     $signed(want.delta_y), want.speed_exceeded, want.three_byte_mode,
                     " got btn=%0d dx=%0d dy=%0d spd=%0d fmt=%0d",
                     got.buttons, $signed(got.delta_x), $signed(got.delta_y),
                     got.speed_exceeded, got.three_byte_mode);
    endtask

    // Track configuration, predict on accepted items, compare accepted samples
    always @(posedge clk or negedge rst_n)
    begin : watch
        smpf_result_t want;
        smpf_result_t got;
        if (!rst_n)
        begin
            radius     = HOLD_RADIUS_RST;
            law_on     = SPEED_LAW_EN_RST;
            law_limit  = MOTION_CAP_RST;
            hold_ticks = JITTER_TICKS_RST;
            phase      = AT_SYNC;
            short_fmt  = 1'b0;
            acc_x      = '0;
            acc_y      = '0;
            btn_now    = '0;
            btn_prev   = LAST_BUTTONS_RST;
            hold_armed = 1'b0;
            hold_count = '0;
            samples_due.delete();
            owed = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_HOLD_RADIUS:  radius     = cfg_data[6:0];
                    CFG_SPEED_LAW_EN: law_on     = cfg_data[0];
                    CFG_MOTION_CAP:   law_limit  = cfg_data[6:0];
                    CFG_JITTER_TICKS: hold_ticks = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (advance_decoder(action, rx_byte, want))
                    samples_due.push_back(want);
            end

            if (out_valid && !out_stall)
            begin
                got.buttons         = buttons;
                got.delta_x         = delta_x;
                got.delta_y         = delta_y;
                got.speed_exceeded  = speed_exceeded;
                got.three_byte_mode = three_byte_mode;
                if (samples_due.size() == 0)
                    report_fault("unexpected", '0, got);
                else
                begin
                    want = samples_due.pop_front();
                    if (got.buttons !== want.buttons || got.delta_x !== want.delta_x ||
                        got.delta_y !== want.delta_y ||
                        got.speed_exceeded !== want.speed_exceeded ||
                        got.three_byte_mode !== want.three_byte_mode)
                        report_fault("mismatch", want, got);
                end
            end
            owed = samples_due.size();
        end
    end

endmodule

@@ tb/sv/serial_mouse_packet_filter_top_test.sv @@
// Stimulus and verdict for the serial mouse packet filter regression.
`timescale 1ns / 1ps

module serial_mouse_packet_filter_top_test;
    import smpf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              speed_exceeded;
    logic              three_byte_mode;
    int                mismatch_count;
    int                samples_owed;

    // Stimulus state
    logic       brisk_send = 1'b0;
    logic       brisk_take = 1'b0;
    logic [2:0] pad_buttons = 3'b111;
    int         hold_span = int'(JITTER_TICKS_RST);
    int         bytes_framed = 0;

    serial_mouse_packet_filter_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .buttons         (buttons),
        .delta_x         (delta_x),
        .delta_y         (delta_y),
        .speed_exceeded  (speed_exceeded),
        .three_byte_mode (three_byte_mode)
    );

    smpf_sample_audit audit (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .buttons         (buttons),
        .delta_x         (delta_x),
        .delta_y         (delta_y),
        .speed_exceeded  (speed_exceeded),
        .three_byte_mode (three_byte_mode),
        .mismatch_count  (mismatch_count),
        .samples_owed    (samples_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drain samples with a random stall before each one
    initial
    begin : take_samples
        int hold;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                brisk_take = !brisk_take;
            hold = brisk_take ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic act, input logic [7:0] payload);
        int gap;
        if ($urandom_range(0, 39) == 0)
            brisk_send = !brisk_send;
        gap = brisk_send ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        rx_byte  <= payload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_item(ACT_TICK, 8'($urandom()));
    endtask

    // Mostly small motion, some full range, some extremes
    function automatic logic [7:0] draw_delta();
        int pick;
        int v;
        pick = $urandom_range(0, 3);
        if (pick < 2)
        begin
            v = int'($urandom_range(0, 6)) - 3;
            return v[7:0];
        end
        if (pick == 2)
            return 8'($urandom());
        case ($urandom_range(0, 3))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h81;
            default: return 8'hff;
        endcase
    endfunction

    // Send a sync byte and its deltas; a cut packet stops early
    task automatic send_packet(input logic cut);
        int deltas;
        int keep;
        int i;
        logic fmt;
        fmt = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            pad_buttons = 3'($urandom_range(0, 7));
        deltas = fmt ? 2 : 4;
        keep = cut ? $urandom_range(0, deltas - 1) : deltas;
        send_item(ACT_BYTE, {SYNC_NIBBLE, fmt, pad_buttons});
        bytes_framed++;
        for (i = 0; i < keep; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_TICK, 8'($urandom()));
            send_item(ACT_BYTE, draw_delta());
            bytes_framed++;
        end
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        int pick;
        stop_at = bytes_framed + budget;
        while (bytes_framed < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_packet(1'b0);
            else if (pick < 67)
                send_packet(1'b1);
            else if (pick < 82)
                send_ticks($urandom_range(1, 4));
            else if (pick < 90)
                send_ticks($urandom_range(1, hold_span + 1));
            else
                send_item(ACT_BYTE, 8'($urandom()));
        end
    endtask

    // Let the block go idle, then write all four registers
    task automatic apply_settings(input logic [6:0] radius, input logic law,
                                  input logic [6:0] limit, input logic [7:0] ticks);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        int k;
        idx = '{CFG_HOLD_RADIUS, CFG_SPEED_LAW_EN, CFG_MOTION_CAP, CFG_JITTER_TICKS};
        val = '{{1'b0, radius}, {7'b0, law}, {1'b0, limit}, ticks};
        in_valid <= 1'b0;
        wait (samples_owed == 0);
        repeat (8) @(negedge clk);
        for (k = 0; k < 4; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        hold_span = int'(ticks);
    endtask

    initial
    begin : stimulus
        logic [8:0] opening [24];
        int i;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_BYTE;
        rx_byte   = '0;
        // noise, lone tick, idle packet, held three-byte packet released by
        // ticks, then a button change with saturating sums
        opening = '{{ACT_BYTE, 8'h00}, {ACT_BYTE, 8'hff}, {ACT_TICK, 8'ha5},
                    {ACT_BYTE, 8'h87}, {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'h00},
                    {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'h00},
                    {ACT_BYTE, 8'h8f}, {ACT_BYTE, 8'h02}, {ACT_BYTE, 8'h00},
                    {ACT_TICK, 8'h00}, {ACT_TICK, 8'h5a}, {ACT_TICK, 8'hff},
                    {ACT_TICK, 8'h00}, {ACT_TICK, 8'h00}, {ACT_TICK, 8'h00},
                    {ACT_TICK, 8'h00}, {ACT_TICK, 8'h00},
                    {ACT_BYTE, 8'h80}, {ACT_BYTE, 8'h7f}, {ACT_BYTE, 8'h80},
                    {ACT_BYTE, 8'h7f}, {ACT_BYTE, 8'h80}};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < 24; i++)
            send_item(opening[i][8], opening[i][7:0]);
        run_random(110);

        apply_settings(7'd127, 1'b1, 7'd0, 8'd1);
        run_random(110);
        apply_settings(7'd0, 1'b1, 7'd127, 8'd255);
        run_random(110);
        apply_settings(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                       7'($urandom_range(0, 127)), 8'($urandom_range(1, 255)));
        run_random(110);
        apply_settings(7'd5, 1'b1, 7'd10, 8'd3);
        run_random(110);
        apply_settings(7'($urandom_range(0, 127)), 1'b1,
                       7'($urandom_range(0, 127)), 8'($urandom_range(1, 16)));
        run_random(110);

        // Drain and give stray samples a chance to show up
        in_valid <= 1'b0;
        wait (samples_owed == 0);
        repeat (24) @(negedge clk);
        if (mismatch_count == 0 && samples_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
src/smpf_pkg.sv
src/smpf_in_reg.sv
src/smpf_core.sv
src/smpf_out_reg.sv
src/serial_mouse_packet_filter_top.sv
tb/sv/smpf_sample_audit.sv
tb/sv/serial_mouse_packet_filter_top_test.sv
